>>> rtl/glzw_pkg.sv
// shared types, constants and helpers of the gif lzw code generator
package glzw_pkg;

    // code space and widths
    localparam int CODE_W      = 12;
    localparam int WIDTH_W     = 4;
    localparam int PIXEL_W     = 8;
    localparam int CFG_W       = 4;
    localparam int FREE_W      = 13;
    localparam int HASH_W      = 13;
    localparam int SUFFIX_SHIFT = 5;
    localparam int ENTRY_W     = 2 * CODE_W + PIXEL_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = 3;

    localparam logic [FREE_W-1:0]  LAST_CODE      = FREE_W'(4095);
    localparam logic [WIDTH_W-1:0] MAX_CODE_WIDTH = WIDTH_W'(12);
    localparam logic [CFG_W-1:0]   MIN_CODE_RESET = CFG_W'(8);
    localparam int                 HASH_ENTRIES_DEF = 8 * 1024;

    // results of one input item, handed to the output queue
    typedef struct packed {
        logic                                    valid;
        logic [QCNT_W-1:0]                       count;
        logic [QUEUE_DEPTH-1:0][CODE_W-1:0]      code;
        logic [QUEUE_DEPTH-1:0][WIDTH_W-1:0]     width;
    } q_load_t;

    // minimum code size as the coder uses it
    function automatic logic [CFG_W-1:0] eff_min(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < CFG_W'(2))
            r = CFG_W'(2);
        else if (v > CFG_W'(9))
            r = CFG_W'(9);
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] clr_code_of(input logic [CFG_W-1:0] m);
        return CODE_W'(1) << m;
    endfunction

    function automatic logic [FREE_W-1:0] first_limit(input logic [CFG_W-1:0] m);
        return FREE_W'(1) << (m + CFG_W'(1));
    endfunction

endpackage

>>> rtl/glzw_dict_mem.sv
// hashed dictionary memory: one write port, one registered read port
module glzw_dict_mem
    import glzw_pkg::*;
#(
    parameter int HASH_ENTRIES = HASH_ENTRIES_DEF,
    parameter int IDX_W = $clog2(HASH_ENTRIES)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [HASH_ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/glzw_out_queue.sv
// holds the codes of one item and hands them out through the output register
module glzw_out_queue
    import glzw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_load_t     load,
    output logic        busy,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic [CODE_W-1:0]  code_reg  [QUEUE_DEPTH];
    logic [WIDTH_W-1:0] width_reg [QUEUE_DEPTH];
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  idx_reg;
    logic               valid_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic [WIDTH_W-1:0] out_width_reg;
    logic               out_last_reg;
    logic               slot_free;

    assign busy      = (idx_reg != cnt_reg);
    assign slot_free = !valid_reg || m_axis_tready;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                code_reg[i]  <= load.code[i];
                width_reg[i] <= load.width[i];
            end
        end
    end

    // fill count and drain pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (slot_free)
            begin
                valid_reg <= busy;
            end
            if (load.valid)
            begin
                cnt_reg <= load.count;
                idx_reg <= '0;
            end
            else if (busy && slot_free)
            begin
                idx_reg <= idx_reg + QCNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (busy && slot_free)
        begin
            out_code_reg  <= code_reg[idx_reg[1:0]];
            out_width_reg <= width_reg[idx_reg[1:0]];
            out_last_reg  <= (idx_reg + QCNT_W'(1) == cnt_reg);
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {out_width_reg, out_code_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> rtl/glzw_core.sv
// lzw sequencer: hash probing, dictionary update, code width and table clears
module glzw_core
    import glzw_pkg::*;
#(
    parameter int HASH_ENTRIES = HASH_ENTRIES_DEF,
    parameter int IDX_W = $clog2(HASH_ENTRIES)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CFG_W-1:0]   min_size,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIXEL_W-1:0] in_pixel,
    input  logic               in_last,
    input  logic               q_busy,
    output q_load_t            q_load,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [ENTRY_W-1:0] wr_data,
    output logic [IDX_W-1:0]   rd_addr,
    input  logic [ENTRY_W-1:0] rd_data
);

    localparam int PRB_W = IDX_W + 1;
    localparam logic [PRB_W-1:0] PRB_LAST = PRB_W'(HASH_ENTRIES - 1);
    localparam logic [PRB_W-1:0] ENTRIES_P = PRB_W'(HASH_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HASH_ENTRIES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]         state_reg,  state_next;
    logic [CODE_W-1:0]  prefix_reg, prefix_next;
    logic [WIDTH_W-1:0] width_reg,  width_next;
    logic [FREE_W-1:0]  free_reg,   free_next;
    logic [FREE_W-1:0]  limit_reg,  limit_next;
    logic               started_reg, started_next;
    logic [CFG_W-1:0]   held_reg,   held_next;
    logic [PIXEL_W-1:0] pix_reg,    pix_next;
    logic               last_reg,   last_next;
    logic [IDX_W-1:0]   hx_reg,     hx_next;
    logic [IDX_W-1:0]   step_reg,   step_next;
    logic [PRB_W-1:0]   probe_reg,  probe_next;
    logic [IDX_W-1:0]   clr_reg,    clr_next;

    logic [CODE_W-1:0]  rd_prefix;
    logic [PIXEL_W-1:0] rd_suffix;
    logic [CODE_W-1:0]  rd_code;

    assign rd_prefix = rd_data[CODE_W-1:0];
    assign rd_suffix = rd_data[CODE_W+PIXEL_W-1:CODE_W];
    assign rd_code   = rd_data[ENTRY_W-1:CODE_W+PIXEL_W];
    assign rd_addr   = hx_reg;
    assign in_ready  = (state_reg == S_IDLE);

    // next-state and result logic
    always_comb
    begin
        logic [CFG_W-1:0]   m;
        logic [CODE_W-1:0]  cc;
        logic [HASH_W-1:0]  hash;
        logic [PRB_W-1:0]   sum;
        logic               hit;
        logic               empty;
        logic               exhausted;
        logic [CODE_W-1:0]  cur;
        logic [WIDTH_W-1:0] w;
        logic               restart;
        logic [QCNT_W-1:0]  n;

        state_next   = state_reg;
        prefix_next  = prefix_reg;
        width_next   = width_reg;
        free_next    = free_reg;
        limit_next   = limit_reg;
        started_next = started_reg;
        held_next    = held_reg;
        pix_next     = pix_reg;
        last_next    = last_reg;
        hx_next      = hx_reg;
        step_next    = step_reg;
        probe_next   = probe_reg;
        clr_next     = clr_reg;
        q_load       = '0;
        wr_en        = 1'b0;
        wr_addr      = hx_reg;
        wr_data      = '0;
        m            = eff_min(min_size);
        cc           = clr_code_of(held_reg);
        hash         = {1'b0, prefix_reg} ^ {in_pixel, SUFFIX_SHIFT'(0)};
        sum          = '0;
        hit          = 1'b0;
        empty        = 1'b0;
        exhausted    = 1'b0;
        cur          = prefix_reg;
        w            = width_reg;
        restart      = 1'b0;
        n            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pix_next  = in_pixel;
                    last_next = in_last;
                    if (!started_reg)
                    begin
                        // first pixel: restart the table and emit a clear code
                        held_next   = m;
                        width_next  = WIDTH_W'(m) + WIDTH_W'(1);
                        free_next   = FREE_W'(clr_code_of(m)) + FREE_W'(2);
                        limit_next  = first_limit(m);
                        prefix_next = CODE_W'(in_pixel);
                        w           = WIDTH_W'(m) + WIDTH_W'(1);
                        q_load.valid    = 1'b1;
                        q_load.code[0]  = clr_code_of(m);
                        q_load.width[0] = w;
                        if (in_last)
                        begin
                            q_load.code[1]  = CODE_W'(in_pixel);
                            q_load.width[1] = w;
                            q_load.code[2]  = clr_code_of(m) + CODE_W'(1);
                            q_load.width[2] = w;
                            q_load.count    = QCNT_W'(3);
                            started_next    = 1'b0;
                            state_next      = S_DRAIN;
                        end
                        else
                        begin
                            q_load.count = QCNT_W'(1);
                            started_next = 1'b1;
                            clr_next     = '0;
                            state_next   = S_CLEAR;
                        end
                    end
                    else
                    begin
                        hx_next    = IDX_W'(hash);
                        step_next  = IDX_W'(1);
                        probe_next = '0;
                        state_next = S_PROBE;
                    end
                end
            end

            S_PROBE:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                empty     = (rd_code == '0);
                hit       = !empty && (rd_prefix == prefix_reg) && (rd_suffix == pix_reg);
                exhausted = !empty && !hit && (probe_reg == PRB_LAST);
                if (!empty && !hit && !exhausted)
                begin
                    // collision: step on by the next odd step
                    sum = {1'b0, hx_reg} + {1'b0, step_reg};
                    if (sum >= ENTRIES_P)
                        sum = sum - ENTRIES_P;
                    hx_next = sum[IDX_W-1:0];
                    sum = {1'b0, step_reg} + PRB_W'(2);
                    if (sum >= ENTRIES_P)
                        sum = sum - ENTRIES_P;
                    step_next  = sum[IDX_W-1:0];
                    probe_next = probe_reg + PRB_W'(1);
                    state_next = S_PROBE;
                end
                else
                begin
                    q_load.valid = 1'b1;
                    if (hit)
                    begin
                        cur = rd_code;
                    end
                    else
                    begin
                        // miss: emit the prefix, store the pair if there is room, adjust width or clear
                        q_load.code[n[1:0]]  = prefix_reg;
                        q_load.width[n[1:0]] = width_reg;
                        n = n + QCNT_W'(1);
                        if (free_reg <= LAST_CODE)
                        begin
                            if (empty)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = hx_reg;
                                wr_data = {free_reg[CODE_W-1:0], pix_reg, prefix_reg};
                            end
                            free_next = free_reg + FREE_W'(1);
                        end
                        if (free_reg == limit_reg)
                        begin
                            if (width_reg < MAX_CODE_WIDTH)
                            begin
                                width_next = width_reg + WIDTH_W'(1);
                                limit_next = limit_reg << 1;
                                w          = width_reg + WIDTH_W'(1);
                            end
                            else
                            begin
                                q_load.code[n[1:0]]  = cc;
                                q_load.width[n[1:0]] = MAX_CODE_WIDTH;
                                n = n + QCNT_W'(1);
                                restart    = 1'b1;
                                w          = WIDTH_W'(held_reg) + WIDTH_W'(1);
                                width_next = w;
                                free_next  = FREE_W'(cc) + FREE_W'(2);
                                limit_next = first_limit(held_reg);
                            end
                        end
                        cur = CODE_W'(pix_reg);
                    end
                    if (last_reg)
                    begin
                        q_load.code[n[1:0]]  = cur;
                        q_load.width[n[1:0]] = w;
                        n = n + QCNT_W'(1);
                        q_load.code[n[1:0]]  = cc + CODE_W'(1);
                        q_load.width[n[1:0]] = w;
                        n = n + QCNT_W'(1);
                        started_next = 1'b0;
                    end
                    q_load.count = n;
                    prefix_next  = cur;
                    clr_next     = '0;
                    state_next   = (restart && !last_reg) ? S_CLEAR : S_DRAIN;
                end
            end

            S_CLEAR:
            begin
                // empty every slot, one a cycle
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == IDX_LAST)
                    state_next = S_DRAIN;
                else
                    clr_next = clr_reg + IDX_W'(1);
            end

            S_DRAIN:
            begin
                if (!q_busy)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            prefix_reg  <= '0;
            width_reg   <= WIDTH_W'(MIN_CODE_RESET) + WIDTH_W'(1);
            free_reg    <= FREE_W'(clr_code_of(MIN_CODE_RESET)) + FREE_W'(2);
            limit_reg   <= first_limit(MIN_CODE_RESET);
            started_reg <= 1'b0;
            held_reg    <= MIN_CODE_RESET;
            probe_reg   <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            prefix_reg  <= prefix_next;
            width_reg   <= width_next;
            free_reg    <= free_next;
            limit_reg   <= limit_next;
            started_reg <= started_next;
            held_reg    <= held_next;
            probe_reg   <= probe_next;
            clr_reg     <= clr_next;
        end
    end

    // item payload and probe position
    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        last_reg <= last_next;
        hx_reg   <= hx_next;
        step_reg <= step_next;
    end

endmodule

>>> rtl/gif_lzw_compressor_unit.sv
// gif lzw code generator, top level
//
// Input channel s_axis: one pixel per item, tlast marks the last pixel of an
// image. Output channel m_axis: one lzw code per item with its bit width;
// tlast marks the final code caused by one input pixel. cfg_wen/cfg_wdata set
// the minimum code size, sampled on the first pixel of each image.
// Per pixel: a pixel that hits or misses on its first probe goes through accept,
// dictionary read, check and hand-off; every further hash probe repeats the
// dictionary read and check. The first pixel of an image and a table-full
// clear code, unless on the image's last pixel, start a clearing pass over
// the dictionary, one slot a cycle, during which no pixel is taken. Up to 4
// codes per pixel leave one per cycle while the receiver is ready.
// Reset empties the control state; the dictionary is cleared by the pass on
// the first pixel. When the receiver stalls, the output register holds its
// code and the block stops taking pixels once its queued codes are pending.
module gif_lzw_compressor_unit
    import glzw_pkg::*;
#(
    parameter int HASH_ENTRIES = HASH_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [3:0]  cfg_wdata,      // minimum code size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // code [11:0], code_width [15:12]
    output logic        m_axis_tlast
);

    localparam int IDX_W = $clog2(HASH_ENTRIES);

    logic [CFG_W-1:0]   min_size_reg;
    q_load_t            q_load;
    logic               q_busy;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_size_reg <= MIN_CODE_RESET;
        else if (cfg_wen)
            min_size_reg <= cfg_wdata;
    end

    glzw_dict_mem #(
        .HASH_ENTRIES (HASH_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    glzw_core #(
        .HASH_ENTRIES (HASH_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .min_size      (min_size_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_pixel      (s_axis_tdata),
        .in_last       (s_axis_tlast),
        .q_busy        (q_busy),
        .q_load        (q_load),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    glzw_out_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (q_load),
        .busy          (q_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> test/tb_top.sv
// testbench of the gif lzw code generator: directed and random pixel images against a built-in code predictor
module tb_top;
    import glzw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS      = 8192;
    localparam int SETTLE_CYC  = 64;
    localparam int MAX_CYCLES  = 4000000;

    typedef enum logic { JOB_PIXEL, JOB_CFG } job_kind_t;

    typedef struct {
        job_kind_t  kind;
        logic [7:0] pixel;
        logic       last;
        logic [3:0] cfg_val;
    } job_t;

    typedef struct {
        logic [11:0] code;
        logic [3:0]  width;
        logic        last;
    } code_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [3:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // pixel
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // code [11:0], code_width [15:12]
    logic        m_axis_tlast;

    job_t       pending_jobs[$];
    code_item_t expected_codes[$];
    int         error_count;
    int         cycle_count;

    // dictionary and coder state of the predictor
    logic [11:0] dict_prefix[NSLOTS];
    logic [7:0]  dict_suffix[NSLOTS];
    logic [11:0] dict_code[NSLOTS];
    logic [11:0] cur_prefix;
    logic [3:0]  cur_width;
    logic [12:0] avail_code;
    logic [12:0] width_limit;
    logic        img_started;
    logic [3:0]  min_reg;
    logic [3:0]  min_held;

    gif_lzw_compressor_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mismatch report
    task automatic report(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // clamp of the minimum code size as the coder uses it
    function automatic logic [3:0] usable_min(input logic [3:0] v);
        if (v < 4'd2)
            return 4'd2;
        if (v > 4'd9)
            return 4'd9;
        return v;
    endfunction

    task automatic restart_dict();
        cur_width   = min_held + 4'd1;
        avail_code  = (13'd1 << min_held) + 13'd2;
        width_limit = 13'd1 << cur_width;
        for (int i = 0; i < NSLOTS; i++)
            dict_code[i] = '0;
    endtask

    task automatic push_code(input logic [11:0] code);
        code_item_t c;
        c.code  = code;
        c.width = cur_width;
        c.last  = 1'b0;
        expected_codes.push_back(c);
    endtask

    // work out the codes caused by one pixel
    task automatic predict_codes(input logic [7:0] pix, input logic last);
        int          base;
        logic [12:0] slot;
        int          step;
        logic        found;
        logic        empty;
        logic [12:0] considered;
        base  = expected_codes.size();
        found = 1'b0;
        empty = 1'b0;
        if (!img_started)
        begin
            min_held = usable_min(min_reg);
            restart_dict();
            push_code(12'd1 << min_held);
            cur_prefix  = {4'd0, pix};
            img_started = 1'b1;
        end
        else
        begin
            slot = {1'b0, cur_prefix} ^ {pix, 5'd0};
            step = 1;
            for (int p = 0; p < NSLOTS; p++)
            begin
                if (dict_code[slot] == '0)
                begin
                    empty = 1'b1;
                    break;
                end
                if (dict_prefix[slot] == cur_prefix && dict_suffix[slot] == pix)
                begin
                    cur_prefix = dict_code[slot];
                    found = 1'b1;
                    break;
                end
                slot = slot + 13'(step);
                step += 2;
            end
            if (!found)
            begin
                considered = avail_code;
                push_code(cur_prefix);
                if (considered <= 13'd4095)
                begin
                    if (empty)
                    begin
                        dict_prefix[slot] = cur_prefix;
                        dict_suffix[slot] = pix;
                        dict_code[slot]   = considered[11:0];
                    end
                    avail_code = considered + 13'd1;
                end
                if (considered == width_limit)
                begin
                    if (cur_width < 4'd12)
                    begin
                        cur_width   = cur_width + 4'd1;
                        width_limit = width_limit << 1;
                    end
                    else
                    begin
                        push_code(12'd1 << min_held);
                        restart_dict();
                    end
                end
                cur_prefix = {4'd0, pix};
            end
        end
        if (last)
        begin
            push_code(cur_prefix);
            push_code((12'd1 << min_held) + 12'd1);
            img_started = 1'b0;
        end
        if (expected_codes.size() > base)
            expected_codes[expected_codes.size() - 1].last = 1'b1;
    endtask

    // sender: pixels with random gaps, register writes only when drained
    int   gap_left;
    int   settle_cnt;
    logic send_burst;
    always @(posedge clk or negedge rst_n)
    begin
        logic       busy;
        logic       nv;
        logic [7:0] nd;
        logic       nl;
        logic       nwen;
        logic [3:0] nwd;
        job_t       j;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            cfg_wen       <= 1'b0;
            cfg_wdata     <= 4'd8;
            gap_left      = 0;
            settle_cnt    = 0;
            send_burst    = 1'b0;
        end
        else
        begin
            nv   = s_axis_tvalid;
            nd   = s_axis_tdata;
            nl   = s_axis_tlast;
            nwen = 1'b0;
            nwd  = cfg_wdata;
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_codes(s_axis_tdata, s_axis_tlast);
                busy = 1'b0;
                nv   = 1'b0;
            end
            if (!busy && pending_jobs.size() > 0)
            begin
                j = pending_jobs[0];
                if (j.kind == JOB_CFG)
                begin
                    // hold off until every code is out and the block settled
                    if (expected_codes.size() == 0)
                        settle_cnt++;
                    else
                        settle_cnt = 0;
                    if (settle_cnt > SETTLE_CYC)
                    begin
                        nwen = 1'b1;
                        nwd  = j.cfg_val;
                        min_reg = j.cfg_val;
                        settle_cnt = 0;
                        void'(pending_jobs.pop_front());
                    end
                end
                else if (gap_left > 0)
                    gap_left--;
                else
                begin
                    nv = 1'b1;
                    nd = j.pixel;
                    nl = j.last;
                    void'(pending_jobs.pop_front());
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                    gap_left = send_burst ? 0 : $urandom_range(0, 9);
                end
            end
            s_axis_tvalid <= nv;
            s_axis_tdata  <= nd;
            s_axis_tlast  <= nl;
            cfg_wen       <= nwen;
            cfg_wdata     <= nwd;
        end
    end

    // receiver: random stalls and code checking
    int   stall_left;
    logic recv_burst;
    always @(posedge clk or negedge rst_n)
    begin
        code_item_t exp_c;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            recv_burst = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_codes.size() == 0)
                    report($sformatf("unexpected code %0d", m_axis_tdata[11:0]));
                else
                begin
                    exp_c = expected_codes.pop_front();
                    if (m_axis_tdata[11:0] != exp_c.code)
                        report($sformatf("code %0d, want %0d",
                                         m_axis_tdata[11:0], exp_c.code));
                    if (m_axis_tdata[15:12] != exp_c.width)
                        report($sformatf("code_width %0d, want %0d",
                                         m_axis_tdata[15:12], exp_c.width));
                    if (m_axis_tlast !== exp_c.last)
                        report($sformatf("end_of_run %0b, want %0b",
                                         m_axis_tlast, exp_c.last));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                stall_left = recv_burst ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_cfg(input logic [3:0] v);
        job_t j;
        j.kind    = JOB_CFG;
        j.cfg_val = v;
        j.pixel   = '0;
        j.last    = 1'b0;
        pending_jobs.push_back(j);
    endtask

    task automatic add_pixel(input logic [7:0] p, input logic last);
        job_t j;
        j.kind    = JOB_PIXEL;
        j.pixel   = p;
        j.last    = last;
        j.cfg_val = '0;
        pending_jobs.push_back(j);
    endtask

    // stimulus and end of run
    initial
    begin
        int         total;
        int         len;
        int         alpha;
        logic [3:0] gen_min;
        logic [3:0] m_eff;
        logic [7:0] p;
        error_count = 0;
        cycle_count = 0;
        cur_prefix  = '0;
        img_started = 1'b0;
        min_reg     = 4'd8;
        min_held    = 4'd8;
        restart_dict();

        // directed: single-pixel image at the widest size
        add_cfg(4'd9);
        add_pixel(8'd0, 1'b1);
        // repeated extreme pixels give dictionary hits
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd128, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd255, 1'b1);
        // size 0 acts as 2
        add_cfg(4'd0);
        for (int i = 0; i < 8; i++)
            add_pixel(8'(i % 4), i == 7);
        // size 15 acts as 9
        add_cfg(4'd15);
        add_pixel(8'd170, 1'b1);
        // size 1 with pixels out of range
        add_cfg(4'd1);
        add_pixel(8'd3, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd85, 1'b0);
        add_pixel(8'd3, 1'b1);
        total   = 20;
        gen_min = 4'd1;

        // random images
        while (total < 420)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                gen_min = 4'($urandom_range(0, 15));
                add_cfg(gen_min);
            end
            m_eff = usable_min(gen_min);
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(1, 3);
                1:       len = $urandom_range(100, 160);
                default: len = $urandom_range(10, 60);
            endcase
            alpha = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 4) : (1 << m_eff);
            if (alpha > (1 << m_eff))
                alpha = 1 << m_eff;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                    p = 8'($urandom_range(0, 255));
                else
                    p = 8'($urandom_range(0, alpha - 1));
                add_pixel(p, i == len - 1);
            end
            total += len;
        end
        add_cfg(4'd8);

        // reset
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_jobs.size() == 0 && !s_axis_tvalid && expected_codes.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> gif_lzw_compressor_unit.f
rtl/glzw_pkg.sv
rtl/glzw_dict_mem.sv
rtl/glzw_out_queue.sv
rtl/glzw_core.sv
rtl/gif_lzw_compressor_unit.sv
test/tb_top.sv
